// ----- hw/rtl/trs_pkg.sv -----
`timescale 1ns / 1ps

package trs_pkg;

	localparam int TAG_BYTES   = 8;
	localparam int DEPTH_WIDTH = 8;
	localparam int TAG_LEN_W   = 4;
	localparam int MATCH_W     = 4;
	localparam int COUNT_W     = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8 * TAG_BYTES;
	localparam int OUT_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TAG_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_LENGTH = 2'd1;

	localparam logic [1:0] PH_SEEK  = 2'd0;
	localparam logic [1:0] PH_CHECK = 2'd1;
	localparam logic [1:0] PH_OK    = 2'd2;
	localparam logic [1:0] PH_FAIL  = 2'd3;

	localparam logic [1:0] LN_DONE = 2'd0;
	localparam logic [1:0] LN_CR   = 2'd1;
	localparam logic [1:0] LN_OPEN = 2'd2;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_O      = 8'h4F;
	localparam logic [7:0] CH_K      = 8'h4B;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [MATCH_W-1:0] OK_LEN = 4'd3;

	localparam logic [TAG_LEN_W-1:0] TAG_LEN_MAX = TAG_LEN_W'(TAG_BYTES);
	localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = {DEPTH_WIDTH{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	function automatic logic [7:0] ok_char(input logic [MATCH_W-1:0] k);
		logic [7:0] c;
		case (k)
			4'd0: c = CH_O;
			4'd1: c = CH_K;
			4'd2: c = CH_SPACE;
			default: c = CH_O;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/tagged_response_scanner.sv -----
`timescale 1ns / 1ps
// Tagged response scanner.
// Input stream s_*: one response byte per request, s_tdata[7:0] is the byte and
// s_tuser marks the first byte of a new response, which clears the scan state.
// Output stream m_*: one result per input byte. m_tuser is set when the byte is
// content to be stored. m_tdata carries the byte, the scan status (seeking tag,
// checking OK, success, failure) and the saturating count of content bytes.
// The configuration port writes the tag characters and the tag length; the user
// must write it only while no request is in flight; the block does not enforce this.
// An accepted request waits in the input register, then moves to the result register.
// Throughput: one byte per cycle while the receiver does not stall; all per-byte work is
// a few compares and small counters between the input register and the result register.
// Reset clears the scan state, sets an all-zero tag of length one and empties
// both registers. When the receiver stalls, the result register holds, the
// input register still takes one more byte, and then s_tready falls until the
// result is taken.
module tagged_response_scanner (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] data_byte
	input  logic                             s_tuser,   // [0] new_response
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] byte_out, [9:8] scan_status, [25:10] content_count, [31:26] zero
	output logic [trs_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tuser,   // [0] store_byte
	input  logic                             cfg_we,
	input  logic [trs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import trs_pkg::*;

	logic [CFG_DATA_W-1:0]  tag_bytes_q;
	logic [TAG_LEN_W-1:0]   tag_length_q;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   new_s1;

	logic [1:0]             phase_q;
	logic [1:0]             line_q;
	logic [DEPTH_WIDTH-1:0] depth_q;
	logic [MATCH_W-1:0]     match_q;
	logic [COUNT_W-1:0]     count_q;

	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic [1:0]             out_status_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic                   out_store_q;

	logic                   advance;
	logic [TAG_LEN_W-1:0]   eff_len;
	logic [7:0]             tag_ch;
	logic [MATCH_W-1:0]     ok_k;

	logic [1:0]             ph_c;
	logic [1:0]             ln_c;
	logic [DEPTH_WIDTH-1:0] dep_c;
	logic [MATCH_W-1:0]     mi_c;
	logic [COUNT_W-1:0]     cnt_c;
	logic                   store_c;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign eff_len  = (tag_length_q > TAG_LEN_MAX) ? TAG_LEN_MAX : tag_length_q;

	always_comb begin
		ph_c    = phase_q;
		ln_c    = line_q;
		dep_c   = depth_q;
		mi_c    = match_q;
		cnt_c   = count_q;
		store_c = 1'b0;
		tag_ch  = 8'd0;
		ok_k    = '0;
		if (new_s1) begin
			ph_c  = PH_SEEK;
			ln_c  = LN_DONE;
			dep_c = '0;
			mi_c  = '0;
			cnt_c = '0;
		end
		if (ph_c == PH_SEEK && mi_c >= eff_len) begin
			ph_c = PH_CHECK;
			mi_c = '0;
		end
		tag_ch = tag_bytes_q[{mi_c[2:0], 3'b000} +: 8];
		case (ph_c)
			PH_SEEK: begin
				store_c = 1'b1;
				if (cnt_c != COUNT_MAX) begin
					cnt_c = cnt_c + 1'b1;
				end
				if (dep_c == '0) begin
					if (ln_c == LN_OPEN) begin
						if (byte_s1 == CH_CR) begin
							ln_c = LN_CR;
						end
					end else if (ln_c == LN_CR) begin
						ln_c = (byte_s1 == CH_LF) ? LN_DONE : LN_OPEN;
					end else if (byte_s1 == tag_ch) begin
						mi_c = mi_c + 1'b1;
					end else begin
						mi_c = '0;
						ln_c = LN_OPEN;
					end
				end
				if (byte_s1 == CH_OPEN) begin
					if (dep_c != DEPTH_MAX) begin
						dep_c = dep_c + 1'b1;
					end
				end else if (byte_s1 == CH_CLOSE) begin
					if (dep_c == '0) begin
						ph_c = PH_FAIL;
					end else begin
						dep_c = dep_c - 1'b1;
					end
				end
			end
			PH_CHECK: begin
				ok_k = (mi_c < OK_LEN) ? mi_c : '0;
				if (byte_s1 != ok_char(ok_k)) begin
					ph_c = PH_FAIL;
				end else begin
					mi_c = ok_k + 1'b1;
					if (mi_c >= OK_LEN) begin
						ph_c = PH_OK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_bytes_q  <= '0;
			tag_length_q <= TAG_LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAG_BYTES:  tag_bytes_q  <= cfg_data;
				CFG_TAG_LENGTH: tag_length_q <= cfg_data[TAG_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			new_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			line_q  <= LN_DONE;
			depth_q <= '0;
			match_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			phase_q <= ph_c;
			line_q  <= ln_c;
			depth_q <= dep_c;
			match_q <= mi_c;
			count_q <= cnt_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q   <= byte_s1;
			out_status_q <= ph_c;
			out_count_q  <= cnt_c;
			out_store_q  <= store_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_store_q;
	assign m_tdata  = {{(OUT_DATA_W - COUNT_W - 10){1'b0}}, out_count_q, out_status_q,
		out_byte_q};

	// A stored byte leaves the scanner either still seeking or failed on a stray close.
	a_store_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_store_q) |->
		(out_status_q == PH_SEEK || out_status_q == PH_FAIL))
		else $error("stored byte with checking or success status");

	// A stored byte has always been counted.
	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_store_q) |-> (out_count_q != '0))
		else $error("stored byte with zero content count");

	// Nesting depth only moves while seeking or on a new response.
	a_depth_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !new_s1 && phase_q != PH_SEEK) |=> $stable(depth_q))
		else $error("paren depth changed outside the seeking phase");

	// A byte waiting in the input register is not lost while the output stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("pending byte dropped during stall");

endmodule

// ----- dv/tagged_response_scanner_test.sv -----
`timescale 1ns / 1ps

module tagged_response_scanner_test;
	import trs_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;
	localparam logic [23:0] OK_WORD = {CH_SPACE, CH_K, CH_O};

	typedef struct packed {
		logic             store;
		logic [7:0]       data;
		logic [1:0]       status;
		logic [COUNT_W-1:0] count;
	} scan_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'h00;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_TAG_BYTES;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state and its copy of the registers, at their reset values.
	logic [CFG_DATA_W-1:0]  cfg_tag_chars = '0;
	logic [TAG_LEN_W-1:0]   cfg_tag_len = 4'd1;
	logic [1:0]             scan_phase = PH_SEEK;
	logic [1:0]             line_mode = LN_DONE;
	logic [DEPTH_WIDTH-1:0] nest_depth = '0;
	logic [MATCH_W-1:0]     tag_pos = '0;
	logic [COUNT_W-1:0]     content_total = '0;

	scan_result_t pending_results[$];
	logic new_pending = 1'b0;
	int   src_gap_pct = 0;
	int   sink_stall_pct = 0;
	int   hold_request = 0;
	int   hold_left = 0;
	int   stall_left = 0;
	int   quiet_cycles = 0;
	int   items_sent = 0;
	int   errors = 0;
	int   status_tally[4] = '{0, 0, 0, 0};

	tagged_response_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic scan_result_t scan_byte(input logic [7:0] b, input logic fresh);
		scan_result_t r;
		logic [TAG_LEN_W-1:0] tag_len_eff;
		logic [MATCH_W-1:0] k;
		if (fresh) begin
			scan_phase = PH_SEEK;
			line_mode = LN_DONE;
			nest_depth = '0;
			tag_pos = '0;
			content_total = '0;
		end
		tag_len_eff = (cfg_tag_len > TAG_LEN_MAX) ? TAG_LEN_MAX : cfg_tag_len;
		r.store = 1'b0;
		if (scan_phase == PH_SEEK && tag_pos >= tag_len_eff) begin
			scan_phase = PH_CHECK;
			tag_pos = '0;
		end
		if (scan_phase == PH_SEEK) begin
			r.store = 1'b1;
			if (content_total != COUNT_MAX)
				content_total = content_total + 1'b1;
			if (nest_depth == '0) begin
				case (line_mode)
					LN_OPEN: begin
						if (b == CH_CR)
							line_mode = LN_CR;
					end
					LN_CR: begin
						line_mode = (b == CH_LF) ? LN_DONE : LN_OPEN;
					end
					default: begin
						if (b == cfg_tag_chars[{tag_pos[2:0], 3'b000} +: 8]) begin
							tag_pos = tag_pos + 1'b1;
						end else begin
							tag_pos = '0;
							line_mode = LN_OPEN;
						end
					end
				endcase
			end
			if (b == CH_OPEN) begin
				if (nest_depth != DEPTH_MAX)
					nest_depth = nest_depth + 1'b1;
			end else if (b == CH_CLOSE) begin
				if (nest_depth == '0)
					scan_phase = PH_FAIL;
				else
					nest_depth = nest_depth - 1'b1;
			end
		end else if (scan_phase == PH_CHECK) begin
			k = (tag_pos < OK_LEN) ? tag_pos : '0;
			if (b != OK_WORD[{k[1:0], 3'b000} +: 8]) begin
				scan_phase = PH_FAIL;
			end else begin
				tag_pos = k + 1'b1;
				if (tag_pos >= OK_LEN)
					scan_phase = PH_OK;
			end
		end
		r.data = b;
		r.status = scan_phase;
		r.count = content_total;
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		scan_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			status_tally[m_tdata[9:8]]++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: byte_out %h, no request pending", m_tdata[7:0]);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tuser !== exp_r.store) begin
					$error("store_byte: expected %0b, actual %0b", exp_r.store, m_tuser);
					errors++;
				end
				if (m_tdata[7:0] !== exp_r.data) begin
					$error("byte_out: expected %h, actual %h", exp_r.data, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[9:8] !== exp_r.status) begin
					$error("scan_status: expected %0d, actual %0d", exp_r.status, m_tdata[9:8]);
					errors++;
				end
				if (m_tdata[25:10] !== exp_r.count) begin
					$error("content_count: expected %0d, actual %0d", exp_r.count,
						m_tdata[25:10]);
					errors++;
				end
				if (m_tdata[31:26] !== 6'd0) begin
					$error("m_tdata[31:26]: expected 0, actual %h", m_tdata[31:26]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
			stall_left = $urandom_range(1, 17) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no request or result moved for %0d cycles.", quiet_cycles);
				$display("tagged_response_scanner test failed");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= new_pending;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(scan_byte(b, new_pending));
		new_pending = 1'b0;
		items_sent++;
	endtask

	task automatic send_text(input string text);
		int i;
		for (i = 0; i < text.len(); i++)
			send_byte(text[i]);
	endtask

	task automatic await_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == CFG_TAG_BYTES)
			cfg_tag_chars = value;
		else if (idx == CFG_TAG_LENGTH)
			cfg_tag_len = value[TAG_LEN_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A response: a few untagged lines with nested parentheses, then the tagged
	// line, whose "OK " is sometimes corrupted, then a little trailing data.
	task automatic send_response();
		int lines, len, opened, i, j, pick, bad_at;
		logic [TAG_LEN_W-1:0] tag_len_eff;
		logic [7:0] c;
		tag_len_eff = (cfg_tag_len > TAG_LEN_MAX) ? TAG_LEN_MAX : cfg_tag_len;
		new_pending = 1'b1;
		lines = $urandom_range(0, 3);
		for (i = 0; i < lines; i++) begin
			len = $urandom_range(1, 10);
			opened = 0;
			for (j = 0; j < len; j++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					c = CH_OPEN;
					opened++;
				end else if (pick == 1 && opened > 0) begin
					c = CH_CLOSE;
					opened--;
				end else if (pick == 2) begin
					c = 8'($urandom);
				end else begin
					c = 8'($urandom_range(8'h30, 8'h5A));
				end
				send_byte(c);
			end
			repeat (opened) send_byte(CH_CLOSE);
			send_byte(CH_CR);
			send_byte(CH_LF);
		end
		for (j = 0; j < int'(tag_len_eff); j++)
			send_byte(cfg_tag_chars[8*j +: 8]);
		bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3;
		for (j = 0; j < 3; j++) begin
			c = OK_WORD[8*j +: 8];
			if (j == bad_at)
				c = c ^ 8'(1 << $urandom_range(0, 7));
			send_byte(c);
		end
		repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 20);
		repeat (n) begin
			new_pending = ($urandom_range(0, 7) == 0);
			send_byte(8'($urandom));
		end
	endtask

	task automatic run_random_traffic(input int n);
		int stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 5) == 0)
				send_noise();
			else
				send_response();
		end
	endtask

	task automatic test_directed_cases();
		src_gap_pct = 20;
		sink_stall_pct = 20;
		new_pending = 1'b1;
		send_byte(8'h00);
		send_text("OK ");
		send_byte(8'hFF);
		await_idle();
		write_reg(CFG_TAG_BYTES, 64'h3141);
		write_reg(CFG_TAG_LENGTH, 64'd2);
		new_pending = 1'b1;
		send_text(")A");
		new_pending = 1'b1;
		send_text("z\015\015\012\015\012A1OK ");
		new_pending = 1'b1;
		send_text("A1OX");
		await_idle();
		write_reg(CFG_TAG_LENGTH, 64'd0);
		new_pending = 1'b1;
		send_text("OK ");
		await_idle();
	endtask

	task automatic test_depth_saturation();
		write_reg(CFG_TAG_BYTES, 64'h3141);
		write_reg(CFG_TAG_LENGTH, 64'd2);
		src_gap_pct = 10;
		sink_stall_pct = 10;
		new_pending = 1'b1;
		repeat (300) send_byte(CH_OPEN);
		repeat (255) send_byte(CH_CLOSE);
		send_byte(CH_CLOSE);
		send_text("OK");
		await_idle();
	endtask

	task automatic test_backpressure();
		src_gap_pct = 0;
		sink_stall_pct = 0;
		hold_request = 160;
		repeat (3) send_response();
		await_idle();
		repeat (3) send_response();
		await_idle();
	endtask

	task automatic test_register_sweep();
		int p;
		logic [TAG_LEN_W-1:0] len;
		logic [CFG_DATA_W-1:0] tag;
		logic [CFG_DATA_W-1:0] noise_bits;
		for (p = 0; p < 12; p++) begin
			await_idle();
			if (p == 0)
				len = 4'd0;
			else if (p == 1)
				len = 4'd15;
			else if (p == 2)
				len = 4'd9;
			else if (p <= 10)
				len = 4'(p - 2);
			else
				len = 4'($urandom_range(0, 15));
			if (p == 3)
				tag = '1;
			else if (p == 4)
				tag = '0;
			else if (p % 2 == 1)
				tag = {$urandom, $urandom};
			else
				for (int i = 0; i < TAG_BYTES; i++)
					tag[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
			noise_bits = {$urandom, $urandom};
			write_reg(CFG_TAG_BYTES, tag);
			write_reg(CFG_TAG_LENGTH, {noise_bits[CFG_DATA_W-1:TAG_LEN_W], len});
			if (p % 4 == 1)
				write_reg(CFG_UNMAPPED_LO, {$urandom, $urandom});
			else if (p % 4 == 3)
				write_reg(CFG_UNMAPPED_HI, {$urandom, $urandom});
			src_gap_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 40);
			sink_stall_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 40);
			run_random_traffic(100);
		end
		await_idle();
	endtask

	task automatic test_full_rate();
		write_reg(CFG_TAG_BYTES, {$urandom, $urandom});
		write_reg(CFG_TAG_LENGTH, 64'd3);
		src_gap_pct = 0;
		sink_stall_pct = 0;
		run_random_traffic(200);
	endtask

	initial begin
		int waited;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_cases();
		test_depth_saturation();
		test_backpressure();
		test_register_sweep();
		test_full_rate();
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < WATCHDOG_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			errors++;
		end
		$display("Sent %0d response bytes over tag lengths 0 to 15, with idling and long stalls.",
			items_sent);
		$display("Results seen: %0d seeking, %0d checking, %0d success, %0d failure.",
			status_tally[PH_SEEK], status_tally[PH_CHECK], status_tally[PH_OK],
			status_tally[PH_FAIL]);
		if (errors == 0)
			$display("tagged_response_scanner test passed");
		else
			$display("tagged_response_scanner test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/trs_pkg.sv
hw/rtl/tagged_response_scanner.sv
dv/tagged_response_scanner_test.sv
